// ----- rtl/vea_pkg.sv -----
// vea_pkg: shared widths, codes and controller/datapath handshake types
// for the vertex element adjacency builder
// no dependencies
package vea_pkg;

  // field widths of the request and result channels
  localparam int unsigned CMD_W  = 1;
  localparam int unsigned ELEM_W = 13;
  localparam int unsigned VERT_W = 12;
  localparam int unsigned OWN_W  = 14;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned SLOT_W = 2;
  localparam int unsigned CNT_W  = 4;

  // default sizing
  localparam int unsigned DEF_MAX_VERTICES = 4096;
  localparam int unsigned DEF_BUCKET_SLOTS = 10;
  localparam int unsigned MAX_ELEMENTS     = 8192;

  // owned element limit after reset
  localparam logic [OWN_W-1:0] OWNED_RESET = OWN_W'(8192);

  // index of the third vertex of a triangle
  localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd2;

  // request commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_OWNED = 2'd2;

  // which kind of result the output register is loaded with
  typedef enum logic [1:0] {
    OUT_SINGLE = 2'd0,
    OUT_EMPTY  = 2'd1,
    OUT_ENTRY  = 2'd2
  } out_kind_e;

  // controller to datapath commands
  typedef struct packed {
    logic      load_item;
    logic      clr_we;
    logic      cnt_re;
    logic      ins_upd;
    logic      bkt_re;
    logic      latch_cnt;
    logic      slot_inc;
    logic      j_clr;
    logic      j_inc;
    logic      out_load;
    out_kind_e out_kind;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic not_owned;
    logic slot_last;
    logic cnt_zero;
    logic j_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/vea_ifs.sv -----
// vea channel interfaces: request, result and configuration write
// depends on vea_pkg for the field widths
interface vea_item_if;
  import vea_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ELEM_W-1:0] element;
  logic [VERT_W-1:0] vertex_a;
  logic [VERT_W-1:0] vertex_b;
  logic [VERT_W-1:0] vertex_c;

  modport source (output valid, command, element, vertex_a, vertex_b, vertex_c,
                  input ready);
  modport sink   (input valid, command, element, vertex_a, vertex_b, vertex_c,
                  output ready);
endinterface

interface vea_result_if;
  import vea_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] vertex_slot;
  logic [CNT_W-1:0]  neighbour_count;
  logic [ELEM_W-1:0] neighbour_element;
  logic              entry_valid;
  logic              last;

  modport source (output valid, status, vertex_slot, neighbour_count,
                  neighbour_element, entry_valid, last, input ready);
  modport sink   (input valid, status, vertex_slot, neighbour_count,
                  neighbour_element, entry_valid, last, output ready);
endinterface

interface vea_cfg_if;
  import vea_pkg::*;
  logic             valid;
  logic             ready;
  logic [OWN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/vea_ram.sv -----
// vea_ram: generic single write port, single read port ram, registered read
// no dependencies
module vea_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read, read data holds when not reading
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/vea_ctrl.sv -----
// vea_ctrl: sequencing state machine for inserts, queries and the count clear
// depends on vea_pkg for the command and status structs
module vea_ctrl import vea_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_INS_RD  = 10'b0000000100,
    S_INS_UPD = 10'b0000001000,
    S_RESULT  = 10'b0000010000,
    S_Q_CNT   = 10'b0000100000,
    S_Q_CHK   = 10'b0001000000,
    S_Q_EMPTY = 10'b0010000000,
    S_Q_RD    = 10'b0100000000,
    S_Q_EMIT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_kind = OUT_SINGLE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          priority if (!sts_i.is_query) begin
            state_d = S_INS_RD;
          end else if (sts_i.not_owned) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_Q_CNT;
          end
        end
      end
      S_INS_RD: begin
        cmd_o.cnt_re = 1'b1;
        state_d = S_INS_UPD;
      end
      S_INS_UPD: begin
        cmd_o.ins_upd  = 1'b1;
        cmd_o.slot_inc = 1'b1;
        state_d = sts_i.slot_last ? S_RESULT : S_INS_RD;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OUT_SINGLE;
          state_d = S_IDLE;
        end
      end
      S_Q_CNT: begin
        cmd_o.cnt_re = 1'b1;
        state_d = S_Q_CHK;
      end
      S_Q_CHK: begin
        cmd_o.latch_cnt = 1'b1;
        cmd_o.j_clr     = 1'b1;
        state_d = sts_i.cnt_zero ? S_Q_EMPTY : S_Q_RD;
      end
      S_Q_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OUT_EMPTY;
          cmd_o.slot_inc = 1'b1;
          state_d = sts_i.slot_last ? S_IDLE : S_Q_CNT;
        end
      end
      S_Q_RD: begin
        cmd_o.bkt_re = 1'b1;
        state_d = S_Q_EMIT;
      end
      S_Q_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OUT_ENTRY;
          cmd_o.j_inc    = 1'b1;
          if (sts_i.j_last) begin
            cmd_o.slot_inc = 1'b1;
            state_d = sts_i.slot_last ? S_IDLE : S_Q_CNT;
          end else begin
            state_d = S_Q_RD;
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/vea_datapath.sv -----
// vea_datapath: item registers, count and bucket memories, output register
// depends on vea_pkg, vea_ifs and vea_ram
module vea_datapath import vea_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned BUCKET_SLOTS = DEF_BUCKET_SLOTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [OWN_W-1:0]  cfg_data_i,
  input  logic [CMD_W-1:0]  in_command_i,
  input  logic [ELEM_W-1:0] in_element_i,
  input  logic [VERT_W-1:0] in_vertex_a_i,
  input  logic [VERT_W-1:0] in_vertex_b_i,
  input  logic [VERT_W-1:0] in_vertex_c_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  vea_result_if.source      out_if
);

  localparam int unsigned VertSpan = 2 ** VERT_W;
  localparam int unsigned CntDepth = (MAX_VERTICES < VertSpan) ? MAX_VERTICES : VertSpan;
  localparam int unsigned CntAw    = (CntDepth > 1) ? $clog2(CntDepth) : 1;
  localparam int unsigned BktDepth = CntDepth * BUCKET_SLOTS;
  localparam int unsigned BktAw    = (BktDepth > 1) ? $clog2(BktDepth) : 1;
  localparam int unsigned IdxW     = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;

  // item registers
  logic [CMD_W-1:0]  cmd_q;
  logic [ELEM_W-1:0] elem_q;
  logic [VERT_W-1:0] vert_a_q, vert_b_q, vert_c_q;
  logic [CNT_W-1:0]  cnt_q;

  // control registers
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [IdxW-1:0]   j_q, j_d;
  logic              full_q, full_d;
  logic [CntAw-1:0]  clr_q, clr_d;
  logic [OWN_W-1:0]  owned_q, owned_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  logic [ELEM_W-1:0] out_elem_q, out_elem_d;
  logic              out_entry_q, out_entry_d;
  logic              out_last_q, out_last_d;

  logic [VERT_W-1:0] vert_sel;
  logic              in_range;
  logic [CntAw-1:0]  cnt_addr;
  logic [BktAw-1:0]  vbase;
  logic [CNT_W-1:0]  rd_cnt;
  logic [CNT_W-1:0]  cnt_raw;
  logic [CNT_W-1:0]  cnt_eff;
  logic              append_ok;
  logic              cnt_we;
  logic [CntAw-1:0]  cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              bkt_we;
  logic [BktAw-1:0]  bkt_waddr;
  logic [BktAw-1:0]  bkt_raddr;
  logic [ELEM_W-1:0] bkt_rdata;
  logic              out_free;
  logic              j_last;

  // vertex of the current slot
  always_comb begin
    unique case (slot_q)
      2'd0:    vert_sel = vert_a_q;
      2'd1:    vert_sel = vert_b_q;
      default: vert_sel = vert_c_q;
    endcase
  end

  // address generation, bucket rows are BUCKET_SLOTS entries apart
  assign in_range  = 32'(vert_sel) < MAX_VERTICES;
  assign cnt_addr  = vert_sel[CntAw-1:0];
  assign vbase     = BktAw'(cnt_addr) * BktAw'(BUCKET_SLOTS);
  assign append_ok = in_range && (32'(rd_cnt) < BUCKET_SLOTS);
  assign bkt_waddr = vbase + BktAw'(rd_cnt);
  assign bkt_raddr = vbase + BktAw'(j_q);

  // query count: out of range reads as empty, clamp to bucket size
  assign cnt_raw = in_range ? rd_cnt : '0;
  assign cnt_eff = (32'(cnt_raw) > BUCKET_SLOTS) ? CNT_W'(BUCKET_SLOTS) : cnt_raw;

  // count memory: clearing pass or append update
  assign cnt_we    = cmd_i.clr_we || (cmd_i.ins_upd && append_ok);
  assign cnt_waddr = cmd_i.clr_we ? clr_q : cnt_addr;
  assign cnt_wdata = cmd_i.clr_we ? '0 : rd_cnt + CNT_W'(1);

  assign bkt_we = cmd_i.ins_upd && append_ok;

  vea_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CntDepth)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.cnt_re),
    .raddr_i (cnt_addr),
    .rdata_o (rd_cnt)
  );

  vea_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (BktDepth)
  ) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (elem_q),
    .re_i    (cmd_i.bkt_re),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  // status back to the controller
  assign out_free = !out_valid_q || out_if.ready;
  assign j_last   = (CNT_W'(j_q) + CNT_W'(1)) == cnt_q;

  always_comb begin
    sts_o.clr_done  = clr_q == CntAw'(CntDepth - 1);
    sts_o.is_query  = in_command_i == CMD_QUERY;
    sts_o.not_owned = ({1'b0, in_element_i} >= owned_q)
                      || (32'(in_element_i) >= MAX_ELEMENTS);
    sts_o.slot_last = slot_q == SLOT_LAST;
    sts_o.cnt_zero  = cnt_eff == '0;
    sts_o.j_last    = j_last;
    sts_o.out_free  = out_free;
  end

  // control next values
  always_comb begin
    slot_d  = slot_q;
    j_d     = j_q;
    full_d  = full_q;
    clr_d   = clr_q;
    owned_d = cfg_we_i ? cfg_data_i : owned_q;
    if (cmd_i.load_item) begin
      slot_d = '0;
      full_d = 1'b0;
    end
    if (cmd_i.slot_inc) begin
      slot_d = slot_q + SLOT_W'(1);
    end
    if (cmd_i.j_clr) begin
      j_d = '0;
    end
    if (cmd_i.j_inc) begin
      j_d = j_q + IdxW'(1);
    end
    if (cmd_i.ins_upd && !append_ok) begin
      full_d = 1'b1;
    end
    if (cmd_i.clr_we) begin
      clr_d = clr_q + CntAw'(1);
    end
  end

  // output register load
  always_comb begin
    out_valid_d  = out_valid_q && !out_if.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_count_d  = out_count_q;
    out_elem_d   = out_elem_q;
    out_entry_d  = out_entry_q;
    out_last_d   = out_last_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      unique case (cmd_i.out_kind)
        OUT_SINGLE: begin
          out_status_d = (cmd_q == CMD_QUERY) ? ST_NOT_OWNED : (full_q ? ST_FULL : ST_OK);
          out_slot_d   = '0;
          out_count_d  = '0;
          out_elem_d   = '0;
          out_entry_d  = 1'b0;
          out_last_d   = 1'b1;
        end
        OUT_EMPTY: begin
          out_status_d = ST_OK;
          out_slot_d   = slot_q;
          out_count_d  = '0;
          out_elem_d   = '0;
          out_entry_d  = 1'b0;
          out_last_d   = slot_q == SLOT_LAST;
        end
        OUT_ENTRY: begin
          out_status_d = ST_OK;
          out_slot_d   = slot_q;
          out_count_d  = cnt_q;
          out_elem_d   = bkt_rdata;
          out_entry_d  = 1'b1;
          out_last_d   = (slot_q == SLOT_LAST) && j_last;
        end
        default: begin
          out_valid_d = out_valid_q && !out_if.ready;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      j_q         <= '0;
      full_q      <= 1'b0;
      clr_q       <= '0;
      owned_q     <= OWNED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      j_q         <= j_d;
      full_q      <= full_d;
      clr_q       <= clr_d;
      owned_q     <= owned_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q    <= in_command_i;
      elem_q   <= in_element_i;
      vert_a_q <= in_vertex_a_i;
      vert_b_q <= in_vertex_b_i;
      vert_c_q <= in_vertex_c_i;
    end
    if (cmd_i.latch_cnt) begin
      cnt_q <= cnt_eff;
    end
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_count_q  <= out_count_d;
    out_elem_q   <= out_elem_d;
    out_entry_q  <= out_entry_d;
    out_last_q   <= out_last_d;
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.status            = out_status_q;
  assign out_if.vertex_slot       = out_slot_q;
  assign out_if.neighbour_count   = out_count_q;
  assign out_if.neighbour_element = out_elem_q;
  assign out_if.entry_valid       = out_entry_q;
  assign out_if.last              = out_last_q;

endmodule

// ----- rtl/vertex_element_adjacency_builder_top.sv -----
// channel   dir  payload                                            handshake
// in_if     in   command, element, vertex_a, vertex_b, vertex_c     valid / ready
// out_if    out  status, vertex_slot, neighbour_count,              valid / ready
//                neighbour_element, entry_valid, last
// cfg_if    in   data (owned_elements)                              valid / ready, ready always high
//
// insert: accept, then per vertex a count read and an append, then the result is loaded;
//   query: accept, then per vertex a count read and a count check, then per listed
//   triangle a bucket read and an output load, or an output load for an empty vertex
// after reset the count memory is cleared one entry a cycle, all min(MAX_VERTICES, 4096) entries,
//   with in_if.ready low
// a stalled out_if holds the sequencer in its output load step; one finished result may wait
//   in the output register while the next request is accepted
// top level of the vertex element adjacency builder
// depends on vea_pkg, vea_ifs, vea_ram, vea_ctrl and vea_datapath
module vertex_element_adjacency_builder_top import vea_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned BUCKET_SLOTS = DEF_BUCKET_SLOTS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vea_item_if.sink     in_if,
  vea_result_if.source out_if,
  vea_cfg_if.sink      cfg_if
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    in_ready;

  // configuration writes are always taken
  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = in_ready;

  vea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  vea_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .BUCKET_SLOTS (BUCKET_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_if.valid),
    .cfg_data_i    (cfg_if.data),
    .in_command_i  (in_if.command),
    .in_element_i  (in_if.element),
    .in_vertex_a_i (in_if.vertex_a),
    .in_vertex_b_i (in_if.vertex_b),
    .in_vertex_c_i (in_if.vertex_c),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .out_if        (out_if)
  );

  // a listed triangle always comes with a non-zero count and ok status
  a_entry_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.entry_valid |-> out_if.neighbour_count != '0 && out_if.status == ST_OK)
    else $error("listed triangle without count");

  // reported count never exceeds the bucket size
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> 32'(out_if.neighbour_count) <= BUCKET_SLOTS)
    else $error("neighbour count above bucket size");

  // error results are single-item answers
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status != ST_OK |-> out_if.last && !out_if.entry_valid)
    else $error("error result not marked last");

endmodule
